// File: hw/rtl/table_dfa_capture_parser_macros.svh
// Assertion macros for the table DFA capture parser.
// Used by the top level only; needs nothing else.
`ifndef TABLE_DFA_CAPTURE_PARSER_MACROS_SVH
`define TABLE_DFA_CAPTURE_PARSER_MACROS_SVH

// ante implies cons on the same edge, checked outside reset
`define TDCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdcp: implication check failed");

// cons holds on the edge after reset was seen high
`define TDCP_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("tdcp: post-reset check failed");

`endif

// File: hw/rtl/tdcp_pkg.sv
// Shared types and constants for the table DFA capture parser.
// No dependencies; imported by the front, queue, back and top modules.
package tdcp_pkg;

   // table geometry
   localparam int NUM_STATES  = 128;
   localparam int ROW_W       = $clog2(NUM_STATES);
   localparam int COL_W       = 8;
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int TABLE_DEPTH = NUM_STATES * (1 << COL_W);
   localparam int WORD_W      = 32;
   localparam int STATE_W     = 16;
   localparam int ACT_W       = 16;

   localparam logic [STATE_W-1:0] ANY_STATE = STATE_W'(1);
   localparam logic [ROW_W-1:0]   ANY_ROW   = ANY_STATE[ROW_W-1:0];
   localparam logic [COL_W-1:0]   WILD_COL  = 8'h2A;   // '*'

   // action flag bits
   localparam int FLAG_MATCH = 15;
   localparam int FLAG_DONE  = 14;
   localparam int FLAG_START = 13;
   localparam int FLAG_END   = 12;
   localparam int END_ID_LSB = 6;

   // capture slots
   localparam int NUM_CAPTURES = 16;
   localparam int CAP_W        = $clog2(NUM_CAPTURES);
   localparam int ID_OUT_W     = 4;

   // message position
   localparam int              POS_W     = 16;
   localparam logic [POS_W-1:0] POS_LIMIT = {{(POS_W-1){1'b1}}, 1'b0};
   localparam int              DONE_W    = POS_W + 1;

   // request beat layout
   localparam int IN_DATA_W    = 56;
   localparam int IN_USER_W    = 2;
   localparam int IN_BYTE_LSB  = 0;
   localparam int IN_ROW_LSB   = 8;
   localparam int IN_COL_LSB   = 15;
   localparam int IN_WORD_LSB  = 23;
   localparam int USER_ACTION  = 0;
   localparam int USER_FIRST   = 1;

   localparam int OUT_DATA_W   = 80;
   localparam int OUT_PAD_W    = 4;

   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic {
      ITEM_BYTE,
      ITEM_WRITE
   } item_kind_type;

   typedef struct packed {
      item_kind_type       kind;
      logic                first;
      logic [COL_W-1:0]    byte_value;
      logic [ADDR_W-1:0]   addr;
      logic [WORD_W-1:0]   word;
   } tdcp_item_type;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic                range_valid;
      logic [ID_OUT_W-1:0] range_slot;
      logic [POS_W-1:0]    range_start;
      logic [POS_W-1:0]    range_length;
      logic                match_valid;
      logic [ID_OUT_W-1:0] match_id;
      logic                done_valid;
      logic [DONE_W-1:0]   done_index;
   } tdcp_result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_RESTEP
   } bk_state_type;

endpackage

// File: hw/rtl/tdcp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; holds the transition table.
module tdcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hw/rtl/tdcp_queue.sv
// Short in-order queue of classified items between front and back.
// Depends on tdcp_pkg for the item type.
module tdcp_queue #(
   parameter int DEPTH = tdcp_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  tdcp_pkg::tdcp_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output tdcp_pkg::tdcp_item_type pop_item
);
   import tdcp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tdcp_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/tdcp_front.sv
// Front end: takes request beats, classifies them as table writes or
// message bytes and hands them to the queue. Depends on tdcp_pkg.
module tdcp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tdcp_pkg::IN_DATA_W-1:0]  req_tdata,
   input  logic [tdcp_pkg::IN_USER_W-1:0]  req_tuser,
   output logic                            push_valid,
   input  logic                            push_ready,
   output tdcp_pkg::tdcp_item_type         push_item
);
   import tdcp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   tdcp_item_type item_ff;
   tdcp_item_type item_in;
   logic          load;

   always_comb begin
      item_in.kind       = req_tuser[USER_ACTION] ? ITEM_WRITE : ITEM_BYTE;
      // first-of-message means nothing on a table write
      item_in.first      = req_tuser[USER_FIRST] && !req_tuser[USER_ACTION];
      item_in.byte_value = req_tdata[IN_BYTE_LSB +: COL_W];
      item_in.addr       = {req_tdata[IN_ROW_LSB +: ROW_W], req_tdata[IN_COL_LSB +: COL_W]};
      item_in.word       = req_tdata[IN_WORD_LSB +: WORD_W];
   end

   assign req_tready = !valid_ff || push_ready;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !push_ready);
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: hw/rtl/tdcp_back.sv
// Back end: runs table writes and DFA steps against the table RAM,
// keeps parser state, position and capture starts, and holds the result.
// Depends on tdcp_pkg.
module tdcp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  tdcp_pkg::tdcp_item_type         pop_item,
   output logic                            ram_wr_en,
   output logic [tdcp_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [tdcp_pkg::WORD_W-1:0]     ram_wr_data,
   output logic                            ram_rd_en,
   output logic [tdcp_pkg::ADDR_W-1:0]     ram_rd_addr_a,
   output logic [tdcp_pkg::ADDR_W-1:0]     ram_rd_addr_b,
   input  logic [tdcp_pkg::WORD_W-1:0]     ram_rd_data_a,
   input  logic [tdcp_pkg::WORD_W-1:0]     ram_rd_data_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tdcp_pkg::tdcp_result_type       rsp_result
);
   import tdcp_pkg::*;

   bk_state_type        state_ff;
   bk_state_type        state_in;
   logic [STATE_W-1:0]  parser_state_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                finished_ff;
   logic [POS_W-1:0]    cap_ff [NUM_CAPTURES];
   logic [COL_W-1:0]    byte_ff;
   logic                rsp_valid_ff;
   tdcp_result_type     rsp_result_ff;
   tdcp_result_type     rsp_result_in;

   logic                first_hit;
   logic [STATE_W-1:0]  eff_state;
   logic [POS_W-1:0]    eff_pos;
   logic                eff_fin;
   logic                skip;
   logic [WORD_W-1:0]   word_sel;
   logic                hit;
   logic [STATE_W-1:0]  nxt;
   logic [ACT_W-1:0]    act;
   logic                f_match;
   logic                f_done;
   logic                f_start;
   logic                f_end;
   logic [CAP_W-1:0]    start_id;
   logic [CAP_W-1:0]    end_id;
   logic [POS_W-1:0]    cap_read;
   logic                out_free;
   logic                restep_need;
   logic                begin_byte;
   logic                resolve;
   logic                finish_restep;

   // a first-of-message byte sees the cleared context
   assign first_hit = (pop_item.kind == ITEM_BYTE) && pop_item.first;
   assign eff_state = first_hit ? '0 : parser_state_ff;
   assign eff_pos   = first_hit ? '0 : pos_ff;
   assign eff_fin   = first_hit ? 1'b0 : finished_ff;
   assign skip      = eff_fin || (eff_pos >= POS_LIMIT);

   // lookup resolve: byte column, then '*' column, then any-state
   assign word_sel = (ram_rd_data_a != '0) ? ram_rd_data_a : ram_rd_data_b;
   assign hit      = (word_sel != '0);
   assign nxt      = hit ? word_sel[STATE_W-1:0] : ANY_STATE;
   assign act      = hit ? word_sel[WORD_W-1:STATE_W] : '0;
   assign f_match  = act[FLAG_MATCH];
   assign f_done   = act[FLAG_DONE];
   assign f_start  = act[FLAG_START];
   assign f_end    = act[FLAG_END];
   assign start_id = act[CAP_W-1:0];
   assign end_id   = act[END_ID_LSB +: CAP_W];
   // start is recorded before the end reads it
   assign cap_read = (f_start && (start_id == end_id)) ? pos_ff : cap_ff[end_id];

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign restep_need = !f_done && (nxt == ANY_STATE);

   always_comb begin
      rsp_result_in.position     = pos_ff;
      rsp_result_in.range_valid  = f_end;
      rsp_result_in.range_slot   = f_end ? act[ID_OUT_W-1:0] : '0;
      rsp_result_in.range_start  = f_end ? cap_read : '0;
      rsp_result_in.range_length = f_end ? (pos_ff - cap_read + 1'b1) : '0;
      rsp_result_in.match_valid  = f_match;
      rsp_result_in.match_id     = f_match ? act[ID_OUT_W-1:0] : '0;
      rsp_result_in.done_valid   = f_done;
      rsp_result_in.done_index   = f_done ? ({1'b0, pos_ff} - 1'b1) : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid && (pop_item.kind == ITEM_BYTE) && !skip) begin
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            if (out_free) begin
               state_in = restep_need ? BK_RESTEP : BK_IDLE;
            end
         end
         BK_RESTEP: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr_a = {eff_state[ROW_W-1:0], pop_item.byte_value};
      ram_rd_addr_b = {eff_state[ROW_W-1:0], WILD_COL};
      begin_byte    = 1'b0;
      resolve       = 1'b0;
      finish_restep = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_item.kind == ITEM_WRITE) begin
                  ram_wr_en = 1'b1;
               end else begin
                  begin_byte = 1'b1;
                  ram_rd_en  = !skip;
               end
            end
         end
         BK_LOOKUP: begin
            if (out_free) begin
               resolve = 1'b1;
               if (restep_need) begin
                  ram_rd_en     = 1'b1;
                  ram_rd_addr_a = {ANY_ROW, byte_ff};
                  ram_rd_addr_b = {ANY_ROW, WILD_COL};
               end
            end
         end
         BK_RESTEP: begin
            finish_restep = 1'b1;
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   assign ram_wr_addr = pop_item.addr;
   assign ram_wr_data = pop_item.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         parser_state_ff <= '0;
         pos_ff          <= '0;
         finished_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_CAPTURES; i++) begin
            cap_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (begin_byte) begin
            parser_state_ff <= eff_state;
            pos_ff          <= eff_pos;
            finished_ff     <= eff_fin;
            if (first_hit) begin
               for (int i = 0; i < NUM_CAPTURES; i++) begin
                  cap_ff[i] <= '0;
               end
            end
         end
         if (resolve) begin
            pos_ff          <= pos_ff + 1'b1;
            parser_state_ff <= nxt;
            if (f_start) begin
               cap_ff[start_id] <= pos_ff;
            end
            if (f_end) begin
               cap_ff[end_id] <= '0;
            end
            if (f_done) begin
               finished_ff <= 1'b1;
            end
         end
         if (finish_restep) begin
            parser_state_ff <= nxt;
         end
         if (resolve) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (resolve) begin
         rsp_result_ff <= rsp_result_in;
      end
      if (begin_byte) begin
         byte_ff <= pop_item.byte_value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// File: hw/rtl/table_dfa_capture_parser.sv
// Table-driven DFA parser with capture tags: front, queue, back, table RAM.
// A message byte's result beat passes the front register, the queue, the table RAM
// read and the lookup state; a step without done that lands in the any-state adds the
// restep state (registered table RAM reads in the lookup loop); skipped bytes and
// table writes stay in idle. Reset (synchronous, active high) clears parser state,
// position, capture starts and the queue; the transition table keeps its contents.
`include "table_dfa_capture_parser_macros.svh"

module table_dfa_capture_parser #(
   parameter int QUEUE_DEPTH = tdcp_pkg::QUEUE_DEPTH   // 2 .. 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // byte_value[7:0], table_row[14:8], table_column[22:15],
   // table_word[54:23], zero [55]
   input  logic [tdcp_pkg::IN_DATA_W-1:0]   req_tdata,
   // action[0], first_of_message[1]
   input  logic [tdcp_pkg::IN_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // position[15:0], range_valid[16], range_slot[20:17], range_start[36:21],
   // range_length[52:37], match_valid[53], match_id[57:54], done_valid[58],
   // done_index[75:59], zero [79:76]
   output logic [tdcp_pkg::OUT_DATA_W-1:0]  rsp_tdata
);
   import tdcp_pkg::*;

   logic              f_push_valid;
   logic              f_push_ready;
   tdcp_item_type     f_push_item;
   logic              q_pop_valid;
   logic              q_pop_ready;
   tdcp_item_type     q_pop_item;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr_a;
   logic [ADDR_W-1:0] ram_rd_addr_b;
   logic [WORD_W-1:0] ram_rd_data_a;
   logic [WORD_W-1:0] ram_rd_data_b;
   tdcp_result_type   rsp_res;
   logic              done_index_ok;
   logic              range_quiet_ok;

   tdcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_item  (f_push_item)
   );

   tdcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_item  (f_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   tdcp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   tdcp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (q_pop_valid),
      .pop_ready     (q_pop_ready),
      .pop_item      (q_pop_item),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_data_b (ram_rd_data_b),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_result    (rsp_res)
   );

   assign rsp_tdata = {OUT_PAD_W'(0),
                       rsp_res.done_index,
                       rsp_res.done_valid,
                       rsp_res.match_id,
                       rsp_res.match_valid,
                       rsp_res.range_length,
                       rsp_res.range_start,
                       rsp_res.range_slot,
                       rsp_res.range_valid,
                       rsp_res.position};

   assign done_index_ok  = (rsp_res.done_index == ({1'b0, rsp_res.position} - 17'd1));
   assign range_quiet_ok = (rsp_res.range_start == '0) && (rsp_res.range_length == '0)
                           && (rsp_res.range_slot == '0);

   `TDCP_ASSERT_IMPLY(a_pos_below_limit, clock, reset, rsp_tvalid, rsp_res.position < POS_LIMIT)
   `TDCP_ASSERT_IMPLY(a_done_index, clock, reset, rsp_tvalid && rsp_res.done_valid, done_index_ok)
   `TDCP_ASSERT_IMPLY(a_range_quiet, clock, reset, rsp_tvalid && !rsp_res.range_valid, range_quiet_ok)
   `TDCP_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_tvalid && !q_pop_valid)

endmodule

// File: tb/testbench.sv
// Self-checking bench for table_dfa_capture_parser: loads the table rows and
// columns that the messages reach, runs directed and random messages, and scores
// each result beat against a built-in parser model. Depends on tdcp_pkg and the RTL.
module testbench;
   import tdcp_pkg::*;

   localparam int CYCLE_LIMIT  = 40000;
   localparam int PAUSE_CYCLES = 20;
   localparam int HOLD_CYCLES  = 500;
   localparam int LIVE_ROWS    = 8;
   localparam int ALPHA_N      = 11;

   typedef struct {
      item_kind_type kind;
      logic          first;
      logic [7:0]    byte_value;
      logic [6:0]    row;
      logic [7:0]    col;
      logic [31:0]   word;
   } req_beat_type;

   typedef struct {
      tdcp_result_type res;
      longint unsigned stamp;
   } parse_report_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic [IN_USER_W-1:0]  req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;

   table_dfa_capture_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // parser model state
   logic [31:0]       dfa_tbl [TABLE_DEPTH];
   logic [STATE_W-1:0] cur_state = '0;
   logic [POS_W-1:0]  msg_pos = '0;
   logic [POS_W-1:0]  cap_start [NUM_CAPTURES];
   logic              msg_over = 1'b0;

   // message bytes come from this set, so only these columns need table words
   logic [7:0] alphabet [ALPHA_N] = '{8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'hFF,
                                      8'hA5, 8'h3C, 8'hC3, 8'h7E, WILD_COL};

   req_beat_type     req_backlog [$];
   req_beat_type     cur_beat;
   parse_report_type parse_reports [$];

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  beats_seen = 0;
   int  hold_left = 0;
   bit  hold_used = 1'b0;
   logic quiet;

   // one stretch where neither side idles
   assign quiet = (cycle_count >= 1000) && (cycle_count < 1300);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] make_word(input bit m, input bit d, input bit s,
                                             input bit e, input logic [11:0] id,
                                             input logic [15:0] nxt);
      logic [15:0] act;
      act = {4'b0, id};
      act[FLAG_MATCH] = m;
      act[FLAG_DONE]  = d;
      act[FLAG_START] = s;
      act[FLAG_END]   = e;
      return {act, nxt};
   endfunction

   function automatic logic [7:0] pick_byte();
      return alphabet[$urandom_range(ALPHA_N - 1)];
   endfunction

   // next states stay in the loaded rows; upper bits exercise the row wrap
   function automatic logic [31:0] rand_entry(input logic [7:0] col);
      logic [15:0] nxt;
      logic [31:0] bits;
      int unsigned roll;
      bits = $urandom;
      roll = $urandom_range(99);
      if (roll < ((col == WILD_COL) ? 15 : 35)) return 32'h0;
      roll = $urandom_range(99);
      if (roll < 55) nxt = {13'b0, bits[2:0]};
      else if (roll < 75) nxt = ANY_STATE;
      else nxt = {bits[15:7], 4'b0, bits[2:0]};
      return make_word($urandom_range(99) < 25, $urandom_range(99) < 3,
                       $urandom_range(99) < 25, $urandom_range(99) < 25,
                       bits[27:16], nxt);
   endfunction

   // entry, then the '*' column, then the any-state with no action
   function automatic logic [31:0] table_lookup(input logic [STATE_W-1:0] st,
                                                input logic [7:0] b);
      logic [31:0] w;
      w = dfa_tbl[{st[ROW_W-1:0], b}];
      if (w == 32'h0) w = dfa_tbl[{st[ROW_W-1:0], WILD_COL}];
      if (w == 32'h0) w = {16'h0, ANY_STATE};
      return w;
   endfunction

   task automatic step_parser(input req_beat_type it);
      tdcp_result_type  r;
      parse_report_type rep;
      logic [31:0]      w;
      logic [15:0]      act;
      logic [POS_W-1:0] here;
      logic [CAP_W-1:0] end_id;
      if (it.kind == ITEM_WRITE) begin
         dfa_tbl[{it.row, it.col}] = it.word;
      end else begin
         if (it.first) begin
            cur_state = '0;
            msg_pos = '0;
            msg_over = 1'b0;
            foreach (cap_start[i]) cap_start[i] = '0;
         end
         if (!msg_over && msg_pos < POS_LIMIT) begin
            r = '0;
            here = msg_pos;
            r.position = here;
            w = table_lookup(cur_state, it.byte_value);
            act = w[31:16];
            cur_state = w[15:0];
            // start is recorded before end, so a shared slot gives length 1
            if (act[FLAG_START]) cap_start[act[CAP_W-1:0]] = here;
            if (act[FLAG_END]) begin
               end_id = act[END_ID_LSB +: CAP_W];
               r.range_valid = 1'b1;
               r.range_slot = act[ID_OUT_W-1:0];
               r.range_start = cap_start[end_id];
               r.range_length = here - cap_start[end_id] + 16'd1;
               cap_start[end_id] = '0;
            end
            if (act[FLAG_MATCH]) begin
               r.match_valid = 1'b1;
               r.match_id = act[ID_OUT_W-1:0];
            end
            msg_pos = here + 16'd1;
            if (act[FLAG_DONE]) begin
               r.done_valid = 1'b1;
               r.done_index = {1'b0, here} - 17'd1;
               msg_over = 1'b1;
            end else if (cur_state == ANY_STATE) begin
               w = table_lookup(ANY_STATE, it.byte_value);
               cur_state = w[15:0];
            end
            rep.res = r;
            rep.stamp = $time;
            parse_reports.push_back(rep);
         end
      end
   endtask

   task automatic add_write(input logic [6:0] row, input logic [7:0] col,
                            input logic [31:0] word);
      req_beat_type it;
      logic [31:0]  bits;
      bits = $urandom;
      it.kind = ITEM_WRITE;
      it.first = bits[8];
      it.byte_value = bits[7:0];
      it.row = row;
      it.col = col;
      it.word = word;
      req_backlog.push_back(it);
   endtask

   task automatic add_byte(input logic [7:0] b, input logic first);
      req_beat_type it;
      logic [31:0]  bits;
      bits = $urandom;
      it.kind = ITEM_BYTE;
      it.first = first;
      it.byte_value = b;
      it.row = bits[6:0];
      it.col = bits[14:7];
      it.word = $urandom;
      req_backlog.push_back(it);
   endtask

   // everything sent and scored, then a latency pause for beats with no result
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || parse_reports.size() != 0)
         @(negedge clock);
      repeat (PAUSE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) step_parser(cur_beat);
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 28)) begin
               cur_beat = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, cur_beat.word, cur_beat.col, cur_beat.row,
                             cur_beat.byte_value};
               req_tuser <= {cur_beat.first, cur_beat.kind};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      parse_report_type rep;
      tdcp_result_type  got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen <= beats_seen + 1;
            got.position     = rsp_tdata[15:0];
            got.range_valid  = rsp_tdata[16];
            got.range_slot   = rsp_tdata[20:17];
            got.range_start  = rsp_tdata[36:21];
            got.range_length = rsp_tdata[52:37];
            got.match_valid  = rsp_tdata[53];
            got.match_id     = rsp_tdata[57:54];
            got.done_valid   = rsp_tdata[58];
            got.done_index   = rsp_tdata[75:59];
            // an expectation stamped this edge cannot have been answered yet
            if (parse_reports.size() == 0 || parse_reports[0].stamp >= $time) begin
               mismatch_count++;
               $display("%0t: result expected none got %h", $time, got);
            end else begin
               rep = parse_reports.pop_front();
               if (rep.res !== got) begin
                  mismatch_count++;
                  $display("%0t: result expected %h got %h", $time, rep.res, got);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 28);
      end
   end

   // one long hold-off on the result side so the request side backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && beats_seen >= 20) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int n_bytes;
      int len;
      logic [6:0] row;
      logic [7:0] col;
      logic [7:0] b;
      foreach (cap_start[i]) cap_start[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every reachable table word before any byte
      for (int r = 0; r < LIVE_ROWS; r++)
         for (int a = 0; a < ALPHA_N; a++)
            add_write(7'(r), alphabet[a], rand_entry(alphabet[a]));

      // directed: start, end with out-of-range next state, wildcard fallback into
      // the any-state with dropped restep actions, double miss, start+end on one
      // slot, done, bytes after done, done at position zero
      add_write(7'd0, 8'h00, make_word(1'b0, 1'b0, 1'b1, 1'b0, 12'd3, 16'd2));
      add_write(7'd2, 8'hFF, make_word(1'b1, 1'b0, 1'b0, 1'b1, {6'd3, 6'd9}, 16'h0082));
      add_write(7'd2, 8'h10, 32'h0);
      add_write(7'd2, WILD_COL, make_word(1'b1, 1'b0, 1'b0, 1'b0, 12'hFFF, ANY_STATE));
      add_write(7'd1, 8'h10, make_word(1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF, 16'd3));
      add_write(7'd3, 8'h20, 32'h0);
      add_write(7'd3, WILD_COL, 32'h0);
      add_write(7'd1, 8'h20, 32'h0);
      add_write(7'd1, WILD_COL, 32'h0);
      add_write(7'd1, 8'h30, make_word(1'b0, 1'b0, 1'b1, 1'b1, {6'd7, 6'd7}, 16'd0));
      add_write(7'd0, 8'h40, make_word(1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 16'd0));
      add_write(7'd127, 8'hFF, 32'hFFFF_FFFF);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h10, 1'b0);
      add_byte(8'h20, 1'b0);
      add_byte(8'h30, 1'b0);
      add_byte(8'h40, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h40, 1'b1);
      wait_drained();

      // random messages, with table patches between phases
      for (int phase = 0; phase < 3; phase++) begin
         if (phase != 0) begin
            for (int k = 0; k < 30; k++) begin
               row = 7'($urandom_range(LIVE_ROWS - 1));
               col = ($urandom_range(99) < 20) ? WILD_COL : pick_byte();
               add_write(row, col, rand_entry(col));
            end
         end
         n_bytes = 0;
         while (n_bytes < 120) begin
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
               b = ($urandom_range(99) < 10) ? WILD_COL : pick_byte();
               // a few runs continue the previous message instead of restarting
               add_byte(b, k == 0 && $urandom_range(99) >= 5);
            end
            n_bytes += len;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && parse_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tdcp_pkg.sv
hw/rtl/tdcp_ram.sv
hw/rtl/tdcp_queue.sv
hw/rtl/tdcp_front.sv
hw/rtl/tdcp_back.sv
hw/rtl/table_dfa_capture_parser.sv
tb/testbench.sv
